[hdl/ellsr_pkg.sv]
// ----------------------------------------------------------------------------
// ellsr_pkg
// Shared types, sizes, codes and helpers of the ELLPACK sparse row unit.
// ----------------------------------------------------------------------------
package ellsr_pkg;

    localparam int ROWS      = 64;
    localparam int SLOTS     = 8;
    localparam int VEC_DEPTH = 64;

    localparam int KIND_W  = 3;
    localparam int ROW_W   = 6;
    localparam int COL_W   = 6;
    localparam int VALUE_W = 32;

    localparam int ENTRIES  = ROWS * SLOTS;
    localparam int ENTRY_AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOT_W   = $clog2(SLOTS + 1);
    localparam int VEC_AW   = $clog2(VEC_DEPTH);
    localparam int PROD_W   = 2 * VALUE_W;
    localparam int ACC_W    = PROD_W + 1 + SLOT_W;
    localparam int FRAC_W   = 16;

    localparam logic [KIND_W-1:0] KIND_SET   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PROD  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_ADD,
        S_PROD,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        MAC_NOP,
        MAC_CLR,
        MAC_MUL,
        MAC_ADD
    } mac_op_t;

    typedef struct packed {
        mac_op_t                   op;
        logic signed [VALUE_W-1:0] a;
        logic signed [VALUE_W-1:0] b;
    } mac_ctl_t;

    typedef struct packed {
        logic                      busy;
        logic signed [VALUE_W-1:0] prod_sat;
        logic signed [VALUE_W-1:0] sum_sat;
    } mac_stat_t;

    typedef struct packed {
        logic [COL_W-1:0]          col;
        logic signed [VALUE_W-1:0] val;
    } entry_t;

    function automatic logic signed [VALUE_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-VALUE_W:0] top_bits;
        top_bits = v[ACC_W-1:VALUE_W-1];
        if ((&top_bits) || !(|top_bits))
            return v[VALUE_W-1:0];
        else if (v[ACC_W-1])
            return {1'b1, {(VALUE_W-1){1'b0}}};
        else
            return {1'b0, {(VALUE_W-1){1'b1}}};
    endfunction

endpackage

[hdl/ellsr_in_if.sv]
// ----------------------------------------------------------------------------
// ellsr_in_if
// Command item channel: kind, row, column and value with valid/ready.
// ----------------------------------------------------------------------------
interface ellsr_in_if
    import ellsr_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output kind, output row, output col, output value,
                    input ready);
    modport sink   (input valid, input kind, input row, input col, input value,
                    output ready);
endinterface

[hdl/ellsr_out_if.sv]
// ----------------------------------------------------------------------------
// ellsr_out_if
// Result item channel: product and status with valid/ready.
// ----------------------------------------------------------------------------
interface ellsr_out_if
    import ellsr_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] product;
    logic                      status;

    modport source (output valid, output product, output status, input ready);
    modport sink   (input valid, input product, input status, output ready);
endinterface

[hdl/ellsr_mac.sv]
// ----------------------------------------------------------------------------
// ellsr_mac
// Shared multiply-accumulate unit: registered 32x32 multiply feeding a wide
// accumulator, also used for the saturating add of an entry update.
// ----------------------------------------------------------------------------
module ellsr_mac
    import ellsr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  mac_ctl_t  ctl,
    output mac_stat_t st
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_v_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  acc_shr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
        end
        else
        begin
            prod_v_reg <= (ctl.op == MAC_MUL);
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        case (ctl.op)
            MAC_CLR: acc_next = '0;
            MAC_ADD: acc_next = ACC_W'(ctl.a) + ACC_W'(ctl.b);
            default:
            begin
                if (prod_v_reg)
                    acc_next = acc_reg + ACC_W'(prod_reg);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ctl.a * ctl.b;
        acc_reg  <= acc_next;
    end

    // floor shift of the Q32.32 sum back to Q16.16
    assign acc_shr     = acc_reg >>> FRAC_W;
    assign st.busy     = prod_v_reg;
    assign st.prod_sat = sat_acc(acc_shr);
    assign st.sum_sat  = sat_acc(acc_reg);

endmodule

[hdl/ellpack_sparse_row_matvec_unit.sv]
// ----------------------------------------------------------------------------
// ellpack_sparse_row_matvec_unit
// ELLPACK sparse row store with entry set/add, vector load, row clear and
// row-by-vector dot product in signed Q16.16.
// ----------------------------------------------------------------------------
// One item is handled at a time; req.ready is high only while idle. Load,
// clear, out-of-range rows and unknown kinds pass from decode straight to
// the finish state. Set and add are bounded by the slot search that reads
// one stored entry per cycle from the entry memory; an add then writes the
// saturated sum in its own add state. A row product streams its entries
// one per cycle through the entry read, the vector read and the shared
// multiplier, then the accumulator drains. A new item can be taken while the
// previous result waits on rsp. No clearing pass is needed after reset.
module ellpack_sparse_row_matvec_unit
    import ellsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ellsr_in_if.sink    req,
    ellsr_out_if.source rsp
);

    state_t state_reg, state_next;

    logic [KIND_W-1:0]         kind_reg, kind_next;
    logic [ROW_W-1:0]          row_reg, row_next;
    logic [COL_W-1:0]          col_reg, col_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [SLOT_W-1:0]         fill_reg, fill_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic [SLOT_W-1:0]         e_slot_reg, e_slot_next;
    logic [SLOT_W-1:0]         hit_slot_reg, hit_slot_next;
    logic                      e_v_reg, e_v_next;
    logic                      v_v_reg, v_v_next;
    logic signed [VALUE_W-1:0] res_prod_reg, res_prod_next;
    logic                      res_stat_reg, res_stat_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] out_product_reg, out_product_next;
    logic                      out_status_reg, out_status_next;

    entry_t                    ent_mem [ENTRIES];
    logic [SLOT_W-1:0]         fill_mem [ROWS];
    logic signed [VALUE_W-1:0] vec_mem [VEC_DEPTH];
    logic [ROWS-1:0]           fill_vld_reg;
    logic [VEC_DEPTH-1:0]      vec_vld_reg;

    entry_t                    ent_rd_reg;
    logic [SLOT_W-1:0]         fill_rd_reg;
    logic                      fill_ok_reg;
    logic signed [VALUE_W-1:0] vec_rd_reg;
    logic                      vec_ok_reg;
    logic signed [VALUE_W-1:0] val_d_reg;

    logic [ENTRY_AW-1:0]       ent_base;
    logic [ENTRY_AW-1:0]       ent_raddr;
    logic                      ent_we;
    logic [ENTRY_AW-1:0]       ent_waddr;
    entry_t                    ent_wdata;
    logic [FILL_AW-1:0]        fill_raddr;
    logic [FILL_AW-1:0]        fill_waddr;
    logic                      fill_we;
    logic [SLOT_W-1:0]         fill_wdata;
    logic                      vec_we;
    logic [SLOT_W-1:0]         fill_cur;
    logic                      row_ok;
    logic                      hit;
    mac_ctl_t                  mac_ctl;
    mac_stat_t                 mac_st;

    ellsr_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .st    (mac_st)
    );

    assign ent_base   = ENTRY_AW'(ENTRY_AW'(row_reg) * ENTRY_AW'(SLOTS));
    assign ent_raddr  = ent_base + ENTRY_AW'(slot_reg);
    assign fill_raddr = FILL_AW'(req.row);
    assign fill_waddr = FILL_AW'(row_reg);
    assign row_ok     = (32'(row_reg) < 32'(ROWS));
    assign fill_cur   = fill_ok_reg ? fill_rd_reg : '0;
    assign hit        = e_v_reg && (ent_rd_reg.col == col_reg);

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.product = out_product_reg;
    assign rsp.status  = out_status_reg;

    // memories
    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_waddr] <= ent_wdata;
        if (fill_we)
            fill_mem[fill_waddr] <= fill_wdata;
        if (vec_we)
            vec_mem[VEC_AW'(col_reg)] <= value_reg;
        ent_rd_reg  <= ent_mem[ent_raddr];
        fill_rd_reg <= fill_mem[fill_raddr];
        fill_ok_reg <= fill_vld_reg[fill_raddr];
        vec_rd_reg  <= vec_mem[VEC_AW'(ent_rd_reg.col)];
        vec_ok_reg  <= vec_vld_reg[VEC_AW'(ent_rd_reg.col)];
        val_d_reg   <= ent_rd_reg.val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_vld_reg <= '0;
            vec_vld_reg  <= '0;
        end
        else
        begin
            if (fill_we)
                fill_vld_reg[fill_waddr] <= 1'b1;
            if (vec_we)
                vec_vld_reg[VEC_AW'(col_reg)] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            e_v_reg       <= 1'b0;
            v_v_reg       <= 1'b0;
            fill_reg      <= '0;
            slot_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            e_v_reg       <= e_v_next;
            v_v_reg       <= v_v_next;
            fill_reg      <= fill_next;
            slot_reg      <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        row_reg         <= row_next;
        col_reg         <= col_next;
        value_reg       <= value_next;
        e_slot_reg      <= e_slot_next;
        hit_slot_reg    <= hit_slot_next;
        res_prod_reg    <= res_prod_next;
        res_stat_reg    <= res_stat_next;
        out_product_reg <= out_product_next;
        out_status_reg  <= out_status_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        value_next       = value_reg;
        fill_next        = fill_reg;
        slot_next        = slot_reg;
        e_slot_next      = e_slot_reg;
        hit_slot_next    = hit_slot_reg;
        e_v_next         = 1'b0;
        v_v_next         = 1'b0;
        res_prod_next    = res_prod_reg;
        res_stat_next    = res_stat_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_product_next = out_product_reg;
        out_status_next  = out_status_reg;
        ent_we           = 1'b0;
        ent_waddr        = ent_base + ENTRY_AW'(fill_reg);
        ent_wdata.col    = col_reg;
        ent_wdata.val    = value_reg;
        fill_we          = 1'b0;
        fill_wdata       = SLOT_W'(fill_reg + 1'b1);
        vec_we           = 1'b0;
        mac_ctl.op       = MAC_NOP;
        mac_ctl.a        = value_reg;
        mac_ctl.b        = ent_rd_reg.val;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next  = req.kind;
                    row_next   = req.row;
                    col_next   = req.col;
                    value_next = req.value;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                fill_next     = fill_cur;
                slot_next     = '0;
                res_prod_next = '0;
                res_stat_next = 1'b0;
                state_next    = S_FIN;
                case (kind_reg)
                    KIND_SET, KIND_ADD:
                    begin
                        if (row_ok)
                            state_next = S_SCAN;
                    end
                    KIND_LOAD:
                    begin
                        vec_we = 1'b1;
                    end
                    KIND_PROD:
                    begin
                        if (row_ok)
                        begin
                            mac_ctl.op = MAC_CLR;
                            state_next = S_PROD;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        if (row_ok)
                        begin
                            fill_we    = 1'b1;
                            fill_wdata = '0;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    if (kind_reg == KIND_SET)
                    begin
                        ent_we     = 1'b1;
                        ent_waddr  = ent_base + ENTRY_AW'(e_slot_reg);
                        state_next = S_FIN;
                    end
                    else
                    begin
                        mac_ctl.op    = MAC_ADD;
                        hit_slot_next = e_slot_reg;
                        state_next    = S_ADD;
                    end
                end
                else if (slot_reg == fill_reg)
                begin
                    // column absent: append or report a full row
                    if (fill_reg < SLOT_W'(SLOTS))
                    begin
                        ent_we  = 1'b1;
                        fill_we = 1'b1;
                    end
                    else
                    begin
                        res_stat_next = 1'b1;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    e_v_next    = 1'b1;
                    e_slot_next = slot_reg;
                    slot_next   = SLOT_W'(slot_reg + 1'b1);
                end
            end

            S_ADD:
            begin
                ent_we        = 1'b1;
                ent_waddr     = ent_base + ENTRY_AW'(hit_slot_reg);
                ent_wdata.val = mac_st.sum_sat;
                state_next    = S_FIN;
            end

            S_PROD:
            begin
                v_v_next = e_v_reg;
                if (slot_reg < fill_reg)
                begin
                    e_v_next  = 1'b1;
                    slot_next = SLOT_W'(slot_reg + 1'b1);
                end
                if (v_v_reg)
                begin
                    mac_ctl.op = MAC_MUL;
                    mac_ctl.a  = val_d_reg;
                    mac_ctl.b  = vec_ok_reg ? vec_rd_reg : '0;
                end
                if ((slot_reg == fill_reg) && !e_v_reg && !v_v_reg && !mac_st.busy)
                begin
                    res_prod_next = mac_st.prod_sat;
                    state_next    = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_product_next = res_prod_reg;
                    out_status_next  = res_stat_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_slot_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= fill_reg)
        else $error("slot counter past fill count");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= SLOT_W'(SLOTS))
        else $error("fill count above slot count");

    a_add_idle_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (mac_ctl.op == MAC_ADD) |-> !mac_st.busy)
        else $error("entry add while multiply in flight");

    a_add_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD) |-> ($past(state_reg) == S_SCAN))
        else $error("add write without a search hit");

    a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && state_next == S_IDLE) |=> out_valid_reg)
        else $error("finished item not presented");

endmodule
